// ===== design/csvt_pkg.sv =====
// Package with the token types and character constants of the CSV byte tokenizer.
package csvt_pkg;

    localparam logic [1:0] KIND_CONTENT  = 2'd0;
    localparam logic [1:0] KIND_CELL_END = 2'd1;
    localparam logic [1:0] KIND_ROW_END  = 2'd2;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    localparam logic [7:0] DELIMITER_RESET = 8'd44;
    localparam logic [7:0] QUOTE_RESET     = 8'd34;

    localparam logic [7:0] REG_DELIMITER    = 8'd0;
    localparam logic [7:0] REG_QUOTE        = 8'd1;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
    } token_t;

    typedef struct packed {
        logic [1:0] count;
        token_t     tok0;
        token_t     tok1;
    } token_pair_t;

endpackage

// ===== design/csvt_if.sv =====
// Interfaces for the byte input, token output and configuration channels.
interface csvt_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       final_byte;

    modport source (output valid, output text_byte, output final_byte, input ready);
    modport sink (input valid, input text_byte, input final_byte, output ready);
endinterface

interface csvt_token_if;
    logic       valid;
    logic       ready;
    logic [1:0] token_kind;
    logic [7:0] content_byte;
    logic       run_end;

    modport source (output valid, output token_kind, output content_byte, output run_end,
                    input ready);
    modport sink (input valid, input token_kind, input content_byte, input run_end,
                  output ready);
endinterface

interface csvt_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] reg_index;
    logic [7:0] write_data;

    modport source (output valid, output reg_index, output write_data, input ready);
    modport sink (input valid, input reg_index, input write_data, output ready);
endinterface

// ===== design/csvt_decoder.sv =====
// Parser state flags and the per-byte decode that yields up to two tokens.
module csvt_decoder
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [7:0]           text_byte,
    input  logic                 final_byte,
    input  logic [7:0]           delimiter_char,
    input  logic [7:0]           quote_char,
    output csvt_pkg::token_pair_t pair
);

    logic inside_quotes_reg, inside_quotes_next;
    logic quote_pending_reg, quote_pending_next;
    logic swallow_lf_reg, swallow_lf_next;
    logic has_content_reg, has_content_next;

    always_comb
    begin
        logic             iq;
        logic             qp;
        logic             chc;
        logic             check_final;
        logic [1:0]       n;
        csvt_pkg::token_t t0;
        csvt_pkg::token_t t1;

        iq          = inside_quotes_reg;
        qp          = quote_pending_reg;
        chc         = has_content_reg;
        check_final = 1'b1;
        n           = 2'd0;
        t0          = '0;
        t1          = '0;
        swallow_lf_next = 1'b0;

        if (swallow_lf_reg && text_byte == csvt_pkg::CHAR_LF)
        begin
            check_final = 1'b0;
        end
        else
        begin
            if (qp && text_byte == quote_char)
            begin
                qp = 1'b0;
                t0.kind = csvt_pkg::KIND_CONTENT;
                t0.data = text_byte;
                n = 2'd1;
                chc = 1'b1;
            end
            else
            begin
                if (qp)
                begin
                    qp = 1'b0;
                    iq = 1'b0;
                end
                if (text_byte == quote_char)
                begin
                    if (!iq)
                        iq = 1'b1;
                    else if (final_byte)
                        iq = 1'b0;
                    else
                        qp = 1'b1;
                end
                else if (!iq && text_byte == delimiter_char)
                begin
                    t0.kind = csvt_pkg::KIND_CELL_END;
                    n = 2'd1;
                    chc = 1'b0;
                end
                else if (!iq && (text_byte == csvt_pkg::CHAR_CR ||
                                 text_byte == csvt_pkg::CHAR_LF))
                begin
                    t0.kind = csvt_pkg::KIND_ROW_END;
                    n = 2'd1;
                    chc = 1'b0;
                    swallow_lf_next = 1'b1;
                    check_final = 1'b0;
                end
                else
                begin
                    t0.kind = csvt_pkg::KIND_CONTENT;
                    t0.data = text_byte;
                    n = 2'd1;
                    chc = 1'b1;
                end
            end

            if (final_byte && check_final && (chc || text_byte == delimiter_char))
            begin
                if (n == 2'd0)
                begin
                    t0.kind = csvt_pkg::KIND_ROW_END;
                    n = 2'd1;
                end
                else
                begin
                    t1.kind = csvt_pkg::KIND_ROW_END;
                    t1.last = 1'b1;
                    n = 2'd2;
                end
                chc = 1'b0;
            end
        end

        t0.last = (n == 2'd1);

        inside_quotes_next = iq;
        quote_pending_next = qp;
        has_content_next   = chc;
        if (final_byte)
        begin
            inside_quotes_next = 1'b0;
            quote_pending_next = 1'b0;
            has_content_next   = 1'b0;
            swallow_lf_next    = 1'b0;
        end

        pair.count = n;
        pair.tok0  = t0;
        pair.tok1  = t1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_quotes_reg <= 1'b0;
            quote_pending_reg <= 1'b0;
            swallow_lf_reg    <= 1'b0;
            has_content_reg   <= 1'b0;
        end
        else if (accept)
        begin
            inside_quotes_reg <= inside_quotes_next;
            quote_pending_reg <= quote_pending_next;
            swallow_lf_reg    <= swallow_lf_next;
            has_content_reg   <= has_content_next;
        end
    end

endmodule

// ===== design/csvt_token_queue.sv =====
// Two-entry token register: takes a decoded token pair, gives one token a cycle when ready.
module csvt_token_queue
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  csvt_pkg::token_pair_t pair,
    output logic                  can_push,
    csvt_token_if.source          token_out
);

    logic [1:0]       count_reg, count_next;
    csvt_pkg::token_t slot0_reg, slot0_next;
    csvt_pkg::token_t slot1_reg, slot1_next;
    logic             pop;

    assign pop      = (count_reg != 2'd0) && token_out.ready;
    assign can_push = (count_reg == 2'd0) || (count_reg == 2'd1 && token_out.ready);

    always_comb
    begin
        count_next = count_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (push)
        begin
            count_next = pair.count;
            slot0_next = pair.tok0;
            slot1_next = pair.tok1;
        end
        else if (pop)
        begin
            count_next = count_reg - 2'd1;
            slot0_next = slot1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    assign token_out.valid        = (count_reg != 2'd0);
    assign token_out.token_kind   = slot0_reg.kind;
    assign token_out.content_byte = slot0_reg.data;
    assign token_out.run_end      = slot0_reg.last;

endmodule

// ===== design/csv_byte_tokenizer.sv =====
// Top level of the CSV byte tokenizer with its configuration registers.
// A byte is decoded in the cycle in which it is accepted, and its tokens sit in the output
// register from the next cycle on. A byte is taken in every cycle as long as the token output
// is ready and each byte yields at most one token; the input also waits while one token is
// held and the output is not ready. A byte that yields two tokens (content or a delimiter
// followed by the closing row mark on the final byte) holds the input until one of them is
// taken; the two-entry token register drains one token per cycle while the output is ready.
// A swallowed line feed, an opening quote and a quote that closes or may close a quoted
// section yield no token but a final quote byte can yield the row mark. Configuration writes
// are taken in every cycle (ready is always high); indexes other than 0 and 1 are ignored.
module csv_byte_tokenizer
(
    input  logic         clk,
    input  logic         rst_n,
    csvt_byte_if.sink    byte_in,
    csvt_token_if.source token_out,
    csvt_cfg_if.sink     cfg
);

    logic [7:0]            delimiter_reg;
    logic [7:0]            quote_reg;
    logic                  can_push;
    logic                  accept;
    csvt_pkg::token_pair_t pair;

    assign cfg.ready     = 1'b1;
    assign byte_in.ready = can_push;
    assign accept        = byte_in.valid && can_push;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delimiter_reg <= csvt_pkg::DELIMITER_RESET;
            quote_reg     <= csvt_pkg::QUOTE_RESET;
        end
        else if (cfg.valid)
        begin
            if (cfg.reg_index == csvt_pkg::REG_DELIMITER)
                delimiter_reg <= cfg.write_data;
            else if (cfg.reg_index == csvt_pkg::REG_QUOTE)
                quote_reg <= cfg.write_data;
        end
    end

    csvt_decoder u_decoder
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .text_byte      (byte_in.text_byte),
        .final_byte     (byte_in.final_byte),
        .delimiter_char (delimiter_reg),
        .quote_char     (quote_reg),
        .pair           (pair)
    );

    csvt_token_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .pair      (pair),
        .can_push  (can_push),
        .token_out (token_out)
    );

endmodule
